### rtl/core/frame_refcount_table_top_defines.svh
// Assertion macros shared by the frame reference count table RTL.
`ifndef FRAME_REFCOUNT_TABLE_TOP_DEFINES_SVH
`define FRAME_REFCOUNT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame_refcount_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame_refcount_table: next-cycle check failed");

`endif

### rtl/core/frt_pkg.sv
// Shared types and constants of the frame reference count table.
`timescale 1ns / 1ps

package frt_pkg;

    localparam int FRAMES_DEF       = 65536;
    localparam int PAGE_SHIFT_DEF   = 12;
    localparam int ADDRESS_BITS_DEF = 48;

    localparam int FRAME_COUNT_W = 17;
    localparam int COUNT_W       = 16;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_EARLY_ALLOC = 3'd0,
        CMD_MARK_ALLOC  = 3'd1,
        CMD_REFERENCE   = 3'd2,
        CMD_DEREFERENCE = 3'd3,
        CMD_QUERY       = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_UNDER   = 3'd2,
        ST_EXHAUST = 3'd3,
        ST_OVER    = 3'd4
    } t_status;

    // Register index taken from the doubleword address bits.
    typedef enum logic [1:0] {
        REG_FRAME_COUNT = 2'd0,
        REG_EARLY_BASE  = 2'd1,
        REG_EARLY_END   = 2'd2
    } t_reg;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

### rtl/core/frt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module frt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/frt_alu.sv
// Shared adder/subtractor; on subtract the carry out reports a >= b.
`timescale 1ns / 1ps

module frt_alu #(
    parameter int WIDTH = 49
) (
    input  frt_pkg::t_alu_op i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH:0]   o_sum
);

    logic [WIDTH-1:0] w_b;
    logic [WIDTH:0]   w_cin;

    always_comb begin
        w_b   = (i_op == frt_pkg::ALU_SUB) ? ~i_b : i_b;
        w_cin = (i_op == frt_pkg::ALU_SUB) ? (WIDTH+1)'(1) : '0;
        o_sum = {1'b0, i_a} + {1'b0, w_b} + w_cin;
    end

endmodule

### rtl/core/frame_refcount_table_top.sv
// Top level of the page-frame reference count table with early bump allocator.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-----------------------------------------
//  command   | in        | i_valid / o_stall   | i_command, i_address
//  result    | out       | o_valid / i_stall   | o_frame_address, o_count,
//            |           |                     | o_free_request, o_status
//  config    | in        | psel/penable/pready | paddr, pwdata, pwrite -> prdata
//
// Early alloc steps through sum, compare and advance after acceptance, the others through
// range compare and count read-modify-write. An exhausted heap ends at the compare; out of
// range, mark at address zero and unused codes end at the range compare. After reset a
// clearing pass zeroes the count RAM, with o_stall high. A finished result waits in the
// output register; one more transaction can be taken meanwhile, and the sequencer then
// holds at its last step until the result leaves.
`timescale 1ns / 1ps
`include "frame_refcount_table_top_defines.svh"

module frame_refcount_table_top #(
    parameter int FRAMES       = frt_pkg::FRAMES_DEF,
    parameter int PAGE_SHIFT   = frt_pkg::PAGE_SHIFT_DEF,
    parameter int ADDRESS_BITS = frt_pkg::ADDRESS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [frt_pkg::CMD_W-1:0]       i_command,
    input  logic [ADDRESS_BITS-1:0]         i_address,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ADDRESS_BITS-1:0]         o_frame_address,
    output logic [frt_pkg::COUNT_W-1:0]     o_count,
    output logic                            o_free_request,
    output logic [frt_pkg::STATUS_W-1:0]    o_status,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [frt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [frt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int W      = ADDRESS_BITS + 1;
    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CW     = frt_pkg::COUNT_W;
    localparam logic [W-1:0]      PAGE_BYTES = W'(1) << PAGE_SHIFT;
    localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_CMP    = 7'b0001000,
        S_NEXT   = 7'b0010000,
        S_RANGE  = 7'b0100000,
        S_MODIFY = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [FIDX_W-1:0]                 r_clr, n_clr;
    logic [frt_pkg::CMD_W-1:0]         r_cmd, n_cmd;
    logic [ADDRESS_BITS-1:0]           r_addr, n_addr;
    logic [W-1:0]                      r_cur, n_cur;
    logic [ADDRESS_BITS-1:0]           r_early_next, n_early_next;

    logic                              r_out_valid, n_out_valid;
    logic [ADDRESS_BITS-1:0]           r_out_fa, n_out_fa;
    logic [CW-1:0]                     r_out_count, n_out_count;
    logic                              r_out_free, n_out_free;
    logic [frt_pkg::STATUS_W-1:0]      r_out_status, n_out_status;

    logic [frt_pkg::FRAME_COUNT_W-1:0] r_frame_count;
    logic [ADDRESS_BITS-1:0]           r_early_base;
    logic [ADDRESS_BITS-1:0]           r_early_end;

    frt_pkg::t_alu_op                  w_alu_op;
    logic [W-1:0]                      w_alu_a, w_alu_b;
    logic [W:0]                        w_alu_sum;

    logic                              w_we;
    logic [FIDX_W-1:0]                 w_waddr;
    logic [CW-1:0]                     w_wdata;
    logic [CW-1:0]                     w_rdata;

    logic [W-1:0]                      w_idx;
    logic [FIDX_W-1:0]                 w_ridx;
    logic [ADDRESS_BITS-1:0]           w_aligned;
    logic [ADDRESS_BITS-1:0]           w_next_sat;
    logic                              w_out_range;
    logic                              w_out_free;
    logic                              w_fin;
    logic                              w_commit;
    logic                              w_mem_wr;
    logic [ADDRESS_BITS-1:0]           w_res_fa;
    logic [CW-1:0]                     w_res_count;
    logic                              w_res_free;
    frt_pkg::t_status                  w_res_status;

    frt_alu #(
        .WIDTH (W)
    ) u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum)
    );

    frt_ram #(
        .WIDTH (CW),
        .DEPTH (FRAMES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_ridx),
        .o_rdata (w_rdata)
    );

    assign w_idx      = W'(r_addr >> PAGE_SHIFT);
    assign w_ridx     = w_idx[FIDX_W-1:0];
    assign w_aligned  = {r_addr[ADDRESS_BITS-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign w_out_free = !r_out_valid || !i_stall;
    // Saturate the early offset instead of letting it wrap.
    assign w_next_sat = w_alu_sum[ADDRESS_BITS] ? {ADDRESS_BITS{1'b1}}
                                                : w_alu_sum[ADDRESS_BITS-1:0];
    assign w_out_range = w_alu_sum[W] || (w_idx >= W'(FRAMES));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_cur        = r_cur;
        n_early_next = r_early_next;
        w_alu_op     = frt_pkg::ALU_ADD;
        w_alu_a      = '0;
        w_alu_b      = '0;
        w_fin        = 1'b0;
        w_mem_wr     = 1'b0;
        w_res_fa     = '0;
        w_res_count  = '0;
        w_res_free   = 1'b0;
        w_res_status = frt_pkg::ST_OK;
        w_we         = 1'b0;
        w_waddr      = w_ridx;
        w_wdata      = '0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == LAST_FRAME) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + FIDX_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_addr  = i_address;
                    n_state = (i_command == frt_pkg::CMD_EARLY_ALLOC) ? S_SUM : S_RANGE;
                end
            end
            S_SUM: begin
                w_alu_a = W'(r_early_base);
                w_alu_b = W'(r_early_next);
                n_cur   = w_alu_sum[W-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                w_alu_op = frt_pkg::ALU_SUB;
                w_alu_a  = r_cur;
                w_alu_b  = W'(r_early_end);
                if (w_alu_sum[W]) begin
                    w_fin        = 1'b1;
                    w_res_status = frt_pkg::ST_EXHAUST;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                w_alu_a  = W'(r_early_next);
                w_alu_b  = PAGE_BYTES;
                w_fin    = 1'b1;
                w_res_fa = r_cur[ADDRESS_BITS-1:0];
                if (w_out_free) begin
                    n_early_next = w_next_sat;
                end
            end
            S_RANGE: begin
                w_alu_op = frt_pkg::ALU_SUB;
                w_alu_a  = w_idx;
                w_alu_b  = W'(r_frame_count);
                if (!(r_cmd inside {frt_pkg::CMD_MARK_ALLOC, frt_pkg::CMD_REFERENCE,
                                    frt_pkg::CMD_DEREFERENCE, frt_pkg::CMD_QUERY})) begin
                    // unused command codes give an all-zero result
                    w_fin = 1'b1;
                end else if (r_cmd == frt_pkg::CMD_MARK_ALLOC && r_addr == '0) begin
                    w_fin = 1'b1;
                end else if (w_out_range) begin
                    w_fin        = 1'b1;
                    w_res_status = frt_pkg::ST_RANGE;
                end else begin
                    n_state = S_MODIFY;
                end
            end
            S_MODIFY: begin
                w_alu_op = (r_cmd == frt_pkg::CMD_DEREFERENCE) ? frt_pkg::ALU_SUB
                                                               : frt_pkg::ALU_ADD;
                w_alu_a  = W'(w_rdata);
                w_alu_b  = W'(1);
                w_fin    = 1'b1;
                case (r_cmd)
                    frt_pkg::CMD_MARK_ALLOC: begin
                        w_mem_wr    = 1'b1;
                        w_wdata     = CW'(1);
                        w_res_count = CW'(1);
                    end
                    frt_pkg::CMD_REFERENCE: begin
                        if (w_rdata == {CW{1'b1}}) begin
                            w_res_status = frt_pkg::ST_OVER;
                            w_res_count  = w_rdata;
                        end else begin
                            w_mem_wr    = 1'b1;
                            w_wdata     = w_alu_sum[CW-1:0];
                            w_res_count = w_alu_sum[CW-1:0];
                        end
                    end
                    frt_pkg::CMD_DEREFERENCE: begin
                        if (w_rdata == '0) begin
                            w_res_status = frt_pkg::ST_UNDER;
                        end else begin
                            w_mem_wr    = 1'b1;
                            w_wdata     = w_alu_sum[CW-1:0];
                            w_res_count = w_alu_sum[CW-1:0];
                            if (w_alu_sum[CW-1:0] == '0) begin
                                w_res_free = 1'b1;
                                w_res_fa   = w_aligned;
                            end
                        end
                    end
                    frt_pkg::CMD_QUERY: begin
                        w_res_count = w_rdata;
                    end
                    default: begin
                        w_mem_wr = 1'b0;
                    end
                endcase
                w_we = w_mem_wr && w_out_free;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_commit = w_fin && w_out_free;

        // output register: drop once taken, load on commit
        n_out_valid  = r_out_valid && i_stall;
        n_out_fa     = r_out_fa;
        n_out_count  = r_out_count;
        n_out_free   = r_out_free;
        n_out_status = r_out_status;
        if (w_commit) begin
            n_state      = S_IDLE;
            n_out_valid  = 1'b1;
            n_out_fa     = w_res_fa;
            n_out_count  = w_res_count;
            n_out_free   = w_res_free;
            n_out_status = w_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_early_next <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_early_next <= n_early_next;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_cur        <= n_cur;
        r_out_fa     <= n_out_fa;
        r_out_count  <= n_out_count;
        r_out_free   <= n_out_free;
        r_out_status <= n_out_status;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_early_base  <= '0;
            r_early_end   <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[frt_pkg::APB_ADDR_W-1:3])
                frt_pkg::REG_FRAME_COUNT: r_frame_count <= pwdata[frt_pkg::FRAME_COUNT_W-1:0];
                frt_pkg::REG_EARLY_BASE:  r_early_base  <= pwdata[ADDRESS_BITS-1:0];
                frt_pkg::REG_EARLY_END:   r_early_end   <= pwdata[ADDRESS_BITS-1:0];
                default: begin
                    r_early_end <= r_early_end;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[frt_pkg::APB_ADDR_W-1:3])
            frt_pkg::REG_FRAME_COUNT: prdata = frt_pkg::APB_DATA_W'(r_frame_count);
            frt_pkg::REG_EARLY_BASE:  prdata = frt_pkg::APB_DATA_W'(r_early_base);
            frt_pkg::REG_EARLY_END:   prdata = frt_pkg::APB_DATA_W'(r_early_end);
            default:                  prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_frame_address = r_out_fa;
    assign o_count         = r_out_count;
    assign o_free_request  = r_out_free;
    assign o_status        = r_out_status;

    `FRT_ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `FRT_ASSERT_NOW(a_ram_write_owner, i_clk, i_rst_n, w_we, r_state == S_CLEAR || r_state == S_MODIFY)
    `FRT_ASSERT_NOW(a_free_means_zero, i_clk, i_rst_n, r_out_valid && r_out_free, r_out_count == '0 && r_out_status == frt_pkg::ST_OK)
    `FRT_ASSERT_NOW(a_range_no_effect, i_clk, i_rst_n, r_out_valid && r_out_status == frt_pkg::ST_RANGE, r_out_count == '0 && !r_out_free && r_out_fa == '0)

endmodule

### tb/sv/frame_refcount_table_top_tb.sv
// Self-checking testbench for the page-frame reference count table and early heap.
`timescale 1ns / 1ps

module frame_refcount_table_top_tb;

    localparam int FRAMES        = frt_pkg::FRAMES_DEF;
    localparam int PAGE_SHIFT    = frt_pkg::PAGE_SHIFT_DEF;
    localparam int ADDR_W        = frt_pkg::ADDRESS_BITS_DEF;
    localparam int FIDX_W        = $clog2(FRAMES);
    localparam int CMD_W         = frt_pkg::CMD_W;
    localparam int COUNT_W       = frt_pkg::COUNT_W;
    localparam int STATUS_W      = frt_pkg::STATUS_W;
    localparam int FRAME_COUNT_W = frt_pkg::FRAME_COUNT_W;
    localparam int APB_ADDR_W    = frt_pkg::APB_ADDR_W;
    localparam int APB_DATA_W    = frt_pkg::APB_DATA_W;

    localparam logic [63:0] ADDR_MASK        = (64'd1 << ADDR_W) - 64'd1;
    localparam logic [63:0] PAGE_BYTES       = 64'd1 << PAGE_SHIFT;
    localparam logic [63:0] FRAME_COUNT_MASK = (64'd1 << FRAME_COUNT_W) - 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int TOP_REFS      = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
    } t_frame_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_addr;
        logic [COUNT_W-1:0]  cnt;
        logic                free_req;
        logic [STATUS_W-1:0] status;
    } t_frame_result;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    logic [CMD_W-1:0]      i_command = '0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    logic [ADDR_W-1:0]     o_frame_address;
    logic [COUNT_W-1:0]    o_count;
    logic                  o_free_request;
    logic [STATUS_W-1:0]   o_status;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the block's state and registers
    logic [COUNT_W-1:0] ref_counts [FRAMES] = '{default: '0};
    logic [63:0]        frame_limit = '0;
    logic [63:0]        heap_base   = '0;
    logic [63:0]        heap_end    = '0;
    logic [63:0]        heap_off    = '0;

    t_frame_cmd    pending_cmds[$];
    t_frame_result expected_results[$];
    logic [63:0]   frame_picks [8];

    bit cmd_taken  = 1'b0;
    int send_idle  = 0;
    int recv_idle  = 0;
    int idle_pct   = 0;
    bit failed     = 1'b0;
    int mismatches = 0;

    frame_refcount_table_top dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        failed = 1'b1;
        // limit log size on a badly broken block
        if (mismatches < MAX_REPORTS)
            $display("%s", msg);
        mismatches++;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("%0t: %s expected %h actual %h", $time, name, want, got));
    endfunction

    function automatic t_frame_result predict_frame_result(input t_frame_cmd c);
        t_frame_result      r;
        logic [63:0]        aligned;
        logic [63:0]        idx;
        logic [63:0]        cur;
        logic [63:0]        nxt;
        logic [FIDX_W-1:0]  slot;
        logic               hit;
        r       = '0;
        aligned = {{(64-ADDR_W){1'b0}}, c.addr} & ~(PAGE_BYTES - 64'd1);
        idx     = {{(64-ADDR_W){1'b0}}, c.addr} >> PAGE_SHIFT;
        hit     = (idx < frame_limit) && (idx < 64'(FRAMES));
        slot    = idx[FIDX_W-1:0];
        case (c.cmd)
            frt_pkg::CMD_EARLY_ALLOC: begin
                cur = heap_base + heap_off;
                if (cur >= heap_end) begin
                    r.status = frt_pkg::ST_EXHAUST;
                end else begin
                    // offset sticks at all ones rather than wrap
                    nxt = heap_off + PAGE_BYTES;
                    if (nxt > ADDR_MASK)
                        nxt = ADDR_MASK;
                    heap_off     = nxt;
                    r.frame_addr = cur[ADDR_W-1:0];
                end
            end
            frt_pkg::CMD_MARK_ALLOC: begin
                if (c.addr != '0) begin
                    if (hit) begin
                        ref_counts[slot] = COUNT_W'(1);
                        r.cnt            = COUNT_W'(1);
                    end else begin
                        r.status = frt_pkg::ST_RANGE;
                    end
                end
            end
            frt_pkg::CMD_REFERENCE: begin
                if (!hit) begin
                    r.status = frt_pkg::ST_RANGE;
                end else begin
                    if (ref_counts[slot] == COUNT_MAX)
                        r.status = frt_pkg::ST_OVER;
                    else
                        ref_counts[slot] = ref_counts[slot] + COUNT_W'(1);
                    r.cnt = ref_counts[slot];
                end
            end
            frt_pkg::CMD_DEREFERENCE: begin
                if (!hit) begin
                    r.status = frt_pkg::ST_RANGE;
                end else if (ref_counts[slot] == '0) begin
                    r.status = frt_pkg::ST_UNDER;
                end else begin
                    ref_counts[slot] = ref_counts[slot] - COUNT_W'(1);
                    r.cnt            = ref_counts[slot];
                    if (ref_counts[slot] == '0) begin
                        r.free_req   = 1'b1;
                        r.frame_addr = aligned[ADDR_W-1:0];
                    end
                end
            end
            frt_pkg::CMD_QUERY: begin
                if (hit)
                    r.cnt = ref_counts[slot];
                else
                    r.status = frt_pkg::ST_RANGE;
            end
            default: ;
        endcase
        return r;
    endfunction

    // monitor: log accepted commands into the predictor, check results
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        if (!i_rst_n) begin
            cmd_taken = 1'b0;
        end else begin
            cmd_taken = i_valid && !o_stall;
            if (cmd_taken)
                expected_results.push_back(
                    predict_frame_result(t_frame_cmd'{cmd: i_command, addr: i_address}));
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf(
                        "%0t: unexpected result expected none actual fa=%h cnt=%h fr=%b st=%h",
                        $time, o_frame_address, o_count, o_free_request, o_status));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("frame_address", 64'(want.frame_addr), 64'(o_frame_address));
                    compare_field("count", 64'(want.cnt), 64'(o_count));
                    compare_field("free_request", 64'(want.free_req), 64'(o_free_request));
                    compare_field("status", 64'(want.status), 64'(o_status));
                end
            end
        end
    end

    // command driver: hold until taken, then advance or idle for a burst
    always @(negedge i_clk) begin : cmd_driver
        t_frame_cmd next_cmd;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cmd_taken) begin
            if (send_idle > 0) begin
                send_idle--;
                i_valid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                send_idle = $urandom_range(0, 5);
                i_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                i_valid   <= 1'b1;
                i_command <= next_cmd.cmd;
                i_address <= next_cmd.addr;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (recv_idle > 0) begin
            recv_idle--;
            i_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            recv_idle = $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic set_register(input frt_pkg::t_reg which, input logic [63:0] value);
        logic [63:0] kept;
        kept = (which == frt_pkg::REG_FRAME_COUNT) ? (value & FRAME_COUNT_MASK)
                                                   : (value & ADDR_MASK);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 3'b000};
        pwdata  <= kept;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (which)
            frt_pkg::REG_FRAME_COUNT: frame_limit = kept;
            frt_pkg::REG_EARLY_BASE:  heap_base   = kept;
            default:                  heap_end    = kept;
        endcase
        // read back the same register
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        compare_field("register readback", kept, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_cmd(input logic [CMD_W-1:0] c, input logic [63:0] a);
        pending_cmds.push_back(t_frame_cmd'{cmd: c, addr: a[ADDR_W-1:0]});
    endfunction

    function automatic void queue_random_cmd();
        int unsigned      r;
        logic [CMD_W-1:0] c;
        logic [63:0]      a;
        r = $urandom_range(0, 99);
        if (r < 10)
            c = frt_pkg::CMD_EARLY_ALLOC;
        else if (r < 25)
            c = frt_pkg::CMD_MARK_ALLOC;
        else if (r < 55)
            c = frt_pkg::CMD_REFERENCE;
        else if (r < 85)
            c = frt_pkg::CMD_DEREFERENCE;
        else if (r < 95)
            c = frt_pkg::CMD_QUERY;
        else
            c = CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
            a = {$urandom, $urandom};
        end else begin
            a = (frame_picks[$urandom_range(0, 7)] << PAGE_SHIFT)
                | 64'($urandom_range(0, int'(PAGE_BYTES) - 1));
            if (a < PAGE_BYTES && $urandom_range(0, 3) == 0)
                a = '0;
        end
        queue_cmd(c, a);
    endfunction

    initial begin : stimulus
        int          ph;
        int          k;
        int unsigned fc;
        logic [63:0] top_addr;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing pass of the count store
        repeat (2) @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);

        // small table, three-page early heap
        set_register(frt_pkg::REG_FRAME_COUNT, 64'd16);
        set_register(frt_pkg::REG_EARLY_BASE, 64'h1_0000);
        set_register(frt_pkg::REG_EARLY_END, 64'h1_3000);
        idle_pct = 20;
        queue_cmd(frt_pkg::CMD_QUERY, 64'h0);
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, 64'h0);        // address zero writes nothing
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, 64'h1000);
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'h1234);
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'h1FFF);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'h1ABC);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'h1001);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'h1FFF);    // drops to zero, free request
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'h1000);    // underflow
        queue_cmd(frt_pkg::CMD_QUERY, 64'h1000);
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'h0);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'hFFF);     // frees page zero
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, 64'hF_FFFF);   // frame 0xFF, past the frame limit
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'h10_0000);   // frame 0x100, past the frame limit
        queue_cmd(frt_pkg::CMD_QUERY, ADDR_MASK);
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, ADDR_MASK);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, ADDR_MASK);
        for (k = 0; k < 4; k++)
            queue_cmd(frt_pkg::CMD_EARLY_ALLOC, ADDR_MASK);
        for (k = CMD_FIRST_UNUSED; k < 8; k++)
            queue_cmd(CMD_W'(k), ADDR_MASK);
        drain();

        // empty table; moving the base carries the heap pointer along
        set_register(frt_pkg::REG_FRAME_COUNT, 64'd0);
        set_register(frt_pkg::REG_EARLY_BASE, 64'h2_0000);
        set_register(frt_pkg::REG_EARLY_END, 64'h2_4000);
        queue_cmd(frt_pkg::CMD_QUERY, 64'h0);
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, 64'h0);
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, 64'h1000);
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'h0);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, 64'h0);
        queue_cmd(frt_pkg::CMD_EARLY_ALLOC, 64'h0);
        queue_cmd(frt_pkg::CMD_EARLY_ALLOC, 64'h0);
        drain();

        // full table, heap at the top of the address space, counts on the last frame
        idle_pct = 0;
        set_register(frt_pkg::REG_FRAME_COUNT, 64'(FRAMES));
        set_register(frt_pkg::REG_EARLY_BASE, (ADDR_MASK & ~(PAGE_BYTES - 64'd1)) - heap_off);
        set_register(frt_pkg::REG_EARLY_END, ADDR_MASK);
        top_addr = 64'(FRAMES - 1) << PAGE_SHIFT;
        queue_cmd(frt_pkg::CMD_EARLY_ALLOC, 64'h0);
        queue_cmd(frt_pkg::CMD_EARLY_ALLOC, 64'h0);
        queue_cmd(frt_pkg::CMD_MARK_ALLOC, top_addr | (PAGE_BYTES - 64'd1));
        for (k = 0; k < TOP_REFS; k++)
            queue_cmd(frt_pkg::CMD_REFERENCE,
                      top_addr | 64'($urandom_range(0, int'(PAGE_BYTES) - 1)));
        queue_cmd(frt_pkg::CMD_QUERY, top_addr);
        queue_cmd(frt_pkg::CMD_DEREFERENCE, top_addr | (PAGE_BYTES - 64'd1));
        queue_cmd(frt_pkg::CMD_REFERENCE, 64'(FRAMES) << PAGE_SHIFT);
        drain();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_pct = (ph == RAND_PHASES - 1) ? 0 : (ph % 3) * 15;
            case ($urandom_range(0, 4))
                0:       fc = 1;
                1:       fc = 8;
                2:       fc = $urandom_range(2, 64);
                3:       fc = FRAMES;
                default: fc = $urandom_range(1, FRAMES);
            endcase
            set_register(frt_pkg::REG_FRAME_COUNT, 64'(fc));
            // a few frames per phase so counts climb and fall back to zero
            frame_picks[0] = 0;
            frame_picks[1] = 64'(fc);
            frame_picks[2] = 64'(fc - 1);
            frame_picks[3] = 64'($urandom_range(0, fc - 1));
            frame_picks[4] = 64'($urandom_range(0, fc - 1));
            frame_picks[5] = 64'($urandom_range(0, fc - 1));
            frame_picks[6] = 64'($urandom_range(0, FRAMES + 7));
            frame_picks[7] = 1;
            if ($urandom_range(0, 1) == 0)
                set_register(frt_pkg::REG_EARLY_BASE,
                             64'($urandom_range(0, 1023)) << PAGE_SHIFT);
            else
                set_register(frt_pkg::REG_EARLY_BASE,
                             {$urandom, $urandom} & ~(PAGE_BYTES - 64'd1));
            if ($urandom_range(0, 9) < 7)
                set_register(frt_pkg::REG_EARLY_END,
                             heap_base + heap_off + (64'($urandom_range(0, 8)) << PAGE_SHIFT));
            else
                set_register(frt_pkg::REG_EARLY_END, {$urandom, $urandom});
            for (k = 0; k < PHASE_ITEMS; k++)
                queue_random_cmd();
            drain();
        end

        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/frt_pkg.sv
rtl/core/frt_ram.sv
rtl/core/frt_alu.sv
rtl/core/frame_refcount_table_top.sv
tb/sv/frame_refcount_table_top_tb.sv
